// ===== rtl/multichannel_prn_iq_synthesizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// multichannel_prn_iq_synthesizer_top_assert.svh
// assertion macros used by the synthesizer checker
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PRN_IQ_SYNTHESIZER_TOP_ASSERT_SVH
`define MULTICHANNEL_PRN_IQ_SYNTHESIZER_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define MPIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define MPIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpis_pkg
// shared constants, types and table functions of the prn i/q synthesizer
// ----------------------------------------------------------------------------
package mpis_pkg;

    // sizing
    localparam int MAX_CHANNELS    = 8;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int AMP_BITS        = 16;

    // fixed field widths
    localparam int PHASE_W    = 32;
    localparam int LFSR_W     = 17;
    localparam int CNT_W      = 4;
    localparam int CH_ID_W    = 4;
    localparam int OUT_W      = 18;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // derived widths
    localparam int QTR_W   = TABLE_ADDR_BITS - 2;
    localparam int QTR_LEN = 1 << QTR_W;
    localparam int MAG_W   = AMP_BITS - 1;
    localparam int SUM_W   = AMP_BITS + $clog2(MAX_CHANNELS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = CFG_IDX_W'(1);

    // shift register seeding
    localparam logic [LFSR_W-1:0] SEED_BASE   = LFSR_W'(32'hACE1);
    localparam logic [LFSR_W-1:0] SEED_STRIDE = LFSR_W'(32'd7919);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // per-channel carrier phase offsets, round(2^32 * 0.3c / 2pi)
    localparam logic [PHASE_W-1:0] CHAN_OFFSET [16] = '{
        32'd0,          32'd205069583,  32'd410139165,  32'd615208748,
        32'd820278331,  32'd1025347913, 32'd1230417496, 32'd1435487079,
        32'd1640556661, 32'd1845626244, 32'd2050695827, 32'd2255765409,
        32'd2460834992, 32'd2665904575, 32'd2870974157, 32'd3076043740
    };

    typedef logic [QTR_LEN-1:0][MAG_W-1:0] t_qtab;

    // sample request travelling down the cell chain
    typedef struct packed {
        logic                        valid;
        logic                        restart;
        logic [PHASE_W-1:0]          phase;
        logic [TABLE_ADDR_BITS-1:0]  idx;
        logic signed [SUM_W-1:0]     isum;
        logic signed [SUM_W-1:0]     qsum;
    } t_tok;

    // quarter-wave sine entry, Q30 taylor series rounded to amplitude
    function automatic logic [MAG_W-1:0] quarter_sin(input int unsigned m);
        longint unsigned mm;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned x5;
        longint unsigned x7;
        longint unsigned x9;
        longint          s;
        longint          v;
        longint          top;
        int              sh;
        mm  = longint'(m);
        x   = (mm * HALF_PI_Q30) >> QTR_W;
        x2  = (x * x) >> 30;
        x3  = (x2 * x) >> 30;
        x5  = (x3 * x2) >> 30;
        x7  = (x5 * x2) >> 30;
        x9  = (x7 * x2) >> 30;
        s   = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120)
            - longint'(x7 / 5040) + longint'(x9 / 362880);
        sh  = 31 - AMP_BITS;
        top = (longint'(1) <<< (AMP_BITS - 1)) - 1;
        if (s < 0) begin
            s = 0;
        end
        v = (s + (longint'(1) <<< (sh - 1))) >>> sh;
        if (v > top) begin
            v = top;
        end
        return MAG_W'(v);
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int m = 0; m < QTR_LEN; m++) begin
            t[m] = quarter_sin(m);
        end
        return t;
    endfunction

    localparam t_qtab             QTAB  = build_qtab();
    localparam logic [MAG_W-1:0]  QPEAK = quarter_sin(QTR_LEN);

    // full-wave signed sine from the quarter table
    function automatic logic signed [AMP_BITS-1:0] table_sin(
        input logic [TABLE_ADDR_BITS-1:0] idx
    );
        logic [1:0]       quad;
        logic [QTR_W-1:0] r;
        logic [MAG_W-1:0] mag;
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        r    = idx[QTR_W-1:0];
        if (quad[0]) begin
            // mirrored quadrant, the peak entry sits past the table end
            if (r == '0) begin
                mag = QPEAK;
            end else begin
                mag = QTAB[QTR_W'(~r + 1'b1)];
            end
        end else begin
            mag = QTAB[r];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // top address bits of a channel's carrier phase
    function automatic logic [TABLE_ADDR_BITS-1:0] phase_index(
        input logic [PHASE_W-1:0] phase,
        input logic [CH_ID_W-1:0] chan
    );
        logic [PHASE_W-1:0] p;
        p = phase + CHAN_OFFSET[chan];
        return p[PHASE_W-1 -: TABLE_ADDR_BITS];
    endfunction

    function automatic logic [LFSR_W-1:0] seed_of(input logic [CH_ID_W-1:0] chan);
        logic [LFSR_W-1:0] s;
        s = SEED_BASE + SEED_STRIDE * {{(LFSR_W - CH_ID_W){1'b0}}, chan};
        return s;
    endfunction

endpackage

// ===== rtl/multichannel_prn_iq_synthesizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_prn_iq_synthesizer_top
// prn-spread multichannel i/q sample generator built as a chain of channel cells
// ----------------------------------------------------------------------------
// Each accepted request produces one summed I/Q sample. The request enters a
// launch stage that owns the shared phase accumulator, then walks through one
// cell per channel (MAX_CHANNELS cells), each stepping its own code register
// and adding its spread carrier term if its index is below channel_count, and
// lands in an output register. Every stage moves in the same cycle, so one
// request is taken and one result given per clock; throughput is limited only
// by downstream ready, and a waiting result does not stop the chain until it
// reaches the last cell. No clearing pass after reset. Register writes
// (phase_step, channel_count) must happen while no request is in flight.
module multichannel_prn_iq_synthesizer_top import mpis_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_restart,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_i_sum,
    output logic signed [OUT_W-1:0] o_q_sum,
    // register writes
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [PHASE_W-1:0] r_phase_step;
    logic [CNT_W-1:0]   r_chan_count;
    logic               adv;
    t_tok               tok [MAX_CHANNELS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_chan_count <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_W-1:0];
                CFG_CHAN_COUNT: r_chan_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // launch stage
    mpis_head u_head (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_restart    (i_restart),
        .i_adv        (adv),
        .i_phase_step (r_phase_step),
        .o_tok        (tok[0])
    );

    // channel cells
    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_cell
        mpis_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (adv),
            .i_chan_id    (CH_ID_W'(g)),
            .i_chan_count (r_chan_count),
            .i_tok        (tok[g]),
            .o_tok        (tok[g+1])
        );
    end

    // scaling and output register
    mpis_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok[MAX_CHANNELS]),
        .i_ready (i_out_ready),
        .o_adv   (adv),
        .o_valid (o_out_valid),
        .o_i_sum (o_i_sum),
        .o_q_sum (o_q_sum)
    );

    assign o_in_ready = adv;

endmodule

// ===== rtl/mpis_head.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpis_head
// shared phase accumulator, launches one sample request into the cell chain
// ----------------------------------------------------------------------------
module mpis_head import mpis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_restart,
    input  logic               i_adv,
    input  logic [PHASE_W-1:0] i_phase_step,
    output t_tok               o_tok
);

    logic [PHASE_W-1:0] r_phase_acc;
    logic [PHASE_W-1:0] n_phase_acc;
    logic [PHASE_W-1:0] cur_phase;
    logic               accept;
    t_tok               r_tok;

    // restart zeroes the phase for this sample
    always_comb begin
        accept      = i_valid && i_adv;
        cur_phase   = i_restart ? '0 : r_phase_acc;
        n_phase_acc = cur_phase + i_phase_step;
    end

    // phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (accept) begin
            r_phase_acc <= n_phase_acc;
        end
    end

    // launch stage, valid under reset, payload with first cell address precomputed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= i_valid;
        end
        if (accept) begin
            r_tok.restart <= i_restart;
            r_tok.phase   <= cur_phase;
            r_tok.idx     <= phase_index(cur_phase, CH_ID_W'(0));
            r_tok.isum    <= '0;
            r_tok.qsum    <= '0;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/mpis_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpis_cell
// one channel: code shift register, sine/cosine lookup, running i/q sums
// ----------------------------------------------------------------------------
module mpis_cell import mpis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [CH_ID_W-1:0] i_chan_id,
    input  logic [CNT_W-1:0]   i_chan_count,
    input  t_tok               i_tok,
    output t_tok               o_tok
);

    logic [LFSR_W-1:0]           r_lfsr;
    logic [LFSR_W-1:0]           cur_lfsr;
    logic [LFSR_W-1:0]           n_lfsr;
    logic                        chip;
    logic                        active;
    logic [TABLE_ADDR_BITS-1:0]  cos_idx;
    logic signed [AMP_BITS-1:0]  sin_v;
    logic signed [AMP_BITS-1:0]  cos_v;
    logic signed [AMP_BITS-1:0]  i_term;
    logic signed [AMP_BITS-1:0]  q_term;
    logic signed [SUM_W-1:0]     n_isum;
    logic signed [SUM_W-1:0]     n_qsum;
    t_tok                        r_tok;

    // code step: feedback from taps 0,2,3,5 enters bit 15
    always_comb begin
        cur_lfsr = i_tok.restart ? seed_of(i_chan_id) : r_lfsr;
        chip     = cur_lfsr[0] ^ cur_lfsr[2] ^ cur_lfsr[3] ^ cur_lfsr[5];
        n_lfsr   = {1'b0, cur_lfsr[LFSR_W-1] | chip, cur_lfsr[LFSR_W-2:1]};
    end

    // carrier lookup and spread contribution
    always_comb begin
        active  = i_chan_id < i_chan_count;
        cos_idx = i_tok.idx + TABLE_ADDR_BITS'(QTR_LEN);
        sin_v   = table_sin(i_tok.idx);
        cos_v   = table_sin(cos_idx);
        if (!active) begin
            i_term = '0;
            q_term = '0;
        end else if (chip) begin
            i_term = cos_v;
            q_term = sin_v;
        end else begin
            i_term = -cos_v;
            q_term = -sin_v;
        end
        n_isum = i_tok.isum + SUM_W'(i_term);
        n_qsum = i_tok.qsum + SUM_W'(q_term);
    end

    // code register steps once per passing sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= seed_of(i_chan_id);
        end else if (i_adv && i_tok.valid) begin
            r_lfsr <= n_lfsr;
        end
    end

    // hand off to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= i_tok.valid;
        end
        if (i_adv) begin
            r_tok.restart <= i_tok.restart;
            r_tok.phase   <= i_tok.phase;
            r_tok.idx     <= phase_index(i_tok.phase, i_chan_id + CH_ID_W'(1));
            r_tok.isum    <= n_isum;
            r_tok.qsum    <= n_qsum;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/mpis_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpis_out
// scales and saturates the chain sums, output register and chain advance
// ----------------------------------------------------------------------------
module mpis_out import mpis_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tok                    i_tok,
    input  logic                    i_ready,
    output logic                    o_adv,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_i_sum,
    output logic signed [OUT_W-1:0] o_q_sum
);

    localparam int DN    = (AMP_BITS >= 15) ? AMP_BITS - 15 : 0;
    localparam int UP    = (AMP_BITS < 15) ? 15 - AMP_BITS : 0;
    localparam int SCL_W = SUM_W + UP;
    localparam int EXT_W = (SCL_W > OUT_W) ? SCL_W : OUT_W;
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-(64'sd1 <<< (OUT_W - 1)));

    logic                    r_valid;
    logic signed [OUT_W-1:0] r_i_sum;
    logic signed [OUT_W-1:0] r_q_sum;
    logic                    load;

    // floor scaling to 16384 = 1.0 with saturation
    function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [SUM_W-1:0] s);
        logic signed [EXT_W-1:0] v;
        v = (EXT_W'(s) >>> DN) <<< UP;
        if (v > SAT_HI) begin
            v = SAT_HI;
        end else if (v < SAT_LO) begin
            v = SAT_LO;
        end
        return OUT_W'(v);
    endfunction

    // chain moves unless the tail holds a result that cannot drain
    always_comb begin
        load  = i_tok.valid && (!r_valid || i_ready);
        o_adv = !i_tok.valid || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_i_sum <= scale_sat(i_tok.isum);
            r_q_sum <= scale_sat(i_tok.qsum);
        end
    end

    assign o_valid = r_valid;
    assign o_i_sum = r_i_sum;
    assign o_q_sum = r_q_sum;

endmodule

// ===== rtl/mpis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpis_checker
// port-level checks of the synthesizer top, attached by bind
// ----------------------------------------------------------------------------
`include "multichannel_prn_iq_synthesizer_top_assert.svh"

module mpis_checker import mpis_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_in_ready,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [OUT_W-1:0] o_i_sum,
    input  logic signed [OUT_W-1:0] o_q_sum
);

    // a stalled result holds its value
    `MPIS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_i_sum) && $stable(o_q_sum),
        "result dropped or changed while stalled")

    // the chain never blocks requests while the output can take a result
    `MPIS_ASSERT_NOW(a_in_ready, !o_out_valid || i_out_ready,
        o_in_ready, "request blocked with free output")

    // nothing leaves right after reset
    `MPIS_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !o_out_valid, "result present after reset")

endmodule

bind multichannel_prn_iq_synthesizer_top mpis_checker u_mpis_checker (.*);
